### rtl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants for the bounded list engine
// Operation and status codes, sizes, and controller/datapath link types.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;

    typedef enum logic [2:0] {
        F_READ    = 3'd0,
        F_APPEND  = 3'd1,
        F_POP     = 3'd2,
        F_INSERT  = 3'd3,
        F_PREPEND = 3'd4,
        F_DELETE  = 3'd5,
        F_REMOVE  = 3'd6,
        F_FIND    = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
    } t_sts;

endpackage

### rtl/ble_req_if.sv
// ----------------------------------------------------------------------------
// ble_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface ble_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [10:0] position;
    logic signed [31:0] item_value;

    modport source (output valid, func, position, item_value, input ready);
    modport sink   (input valid, func, position, item_value, output ready);
endinterface

### rtl/ble_rsp_if.sv
// ----------------------------------------------------------------------------
// ble_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ble_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_out;
    logic [9:0]         found_at;
    logic [10:0]        removed_count;
    logic [10:0]        length_now;
    logic [2:0]         status;

    modport source (output valid, data_out, found_at, removed_count, length_now, status,
                    input ready);
    modport sink   (input valid, data_out, found_at, removed_count, length_now, status,
                    output ready);
endinterface

### rtl/bounded_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_list_engine_unit: fixed-capacity ordered list of signed words
// Read, append, pop, insert, prepend, delete, remove-all and find over a
// 1024-entry single-port-write memory.
// Sequence: accept, walk the entries, finish, then present the result. No entry
//   is walked for append, any error or an empty list; one for read and pop;
//   up to the element count for insert, prepend, delete, remove-all and find.
// One request at a time: a new word is accepted only after the result is taken.
// Reset clears the element count; entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_list_engine_unit import ble_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    ble_req_if.sink  i_req,
    ble_rsp_if.source o_rsp
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic [WORD_BITS-1:0] dp_data;
    logic [IDX_W-1:0]     dp_found;
    logic [CNT_W-1:0]     dp_removed;
    logic [CNT_W-1:0]     dp_length;
    logic [2:0]           dp_status;

    ble_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ble_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_position   (i_req.position),
        .i_item_value (i_req.item_value),
        .o_data       (dp_data),
        .o_found      (dp_found),
        .o_removed    (dp_removed),
        .o_length     (dp_length),
        .o_status     (dp_status)
    );

    assign o_rsp.data_out      = dp_data;
    assign o_rsp.found_at      = dp_found;
    assign o_rsp.removed_count = dp_removed;
    assign o_rsp.length_now    = dp_length;
    assign o_rsp.status        = dp_status;

endmodule

### rtl/ble_ctrl.sv
// ----------------------------------------------------------------------------
// ble_ctrl: request sequencer
// Accepts a word, runs the datapath memory walk, finishes and presents result.
// ----------------------------------------------------------------------------
module ble_ctrl import ble_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_FIN  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_WALK;
            S_WALK: if (i_sts.walk_done) n_state = S_FIN;
            S_FIN:  n_state = S_RESP;
            S_RESP: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_RESP);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.walk   = (r_state == S_WALK);
    assign o_cmd.finish = (r_state == S_FIN);

endmodule

### rtl/ble_dp.sv
// ----------------------------------------------------------------------------
// ble_dp: list datapath
// Entry memory, element count, walk pointers and result registers.
// ----------------------------------------------------------------------------
module ble_dp import ble_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic [2:0]                  i_func,
    input  logic signed [10:0]          i_position,
    input  logic signed [WORD_BITS-1:0] i_item_value,
    output logic [WORD_BITS-1:0]        o_data,
    output logic [IDX_W-1:0]            o_found,
    output logic [CNT_W-1:0]            o_removed,
    output logic [CNT_W-1:0]            o_length,
    output logic [2:0]                  o_status
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] mem_q;

    logic [CNT_W-1:0]     r_cnt;
    t_func                r_func;
    logic [WORD_BITS-1:0] r_val;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_left;
    logic                 r_down;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_paddr;
    logic [CNT_W-1:0]     r_k;
    t_status              r_st;
    logic [WORD_BITS-1:0] r_cap;
    logic [IDX_W-1:0]     r_found;
    logic [WORD_BITS-1:0] r_res_data;
    logic [IDX_W-1:0]     r_res_found;
    logic [CNT_W-1:0]     r_res_removed;
    t_status              r_res_st;
    logic [WORD_BITS-1:0] n_res_data;
    logic [IDX_W-1:0]     n_res_found;
    logic [CNT_W-1:0]     n_res_removed;

    // load-time decode
    logic signed [11:0]   pos_ext, adj;
    logic                 in_rng, full, empty;
    logic [CNT_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     ld_idx, ld_ptr;
    logic [CNT_W-1:0]     ld_left;
    logic                 ld_down;
    t_status              ld_st;
    logic                 rd_en;
    logic                 we;
    logic [IDX_W-1:0]     wa;
    logic [WORD_BITS-1:0] wd;

    always_comb begin
        pos_ext = {i_position[10], i_position};
        adj     = i_position[10] ? pos_ext + $signed({1'b0, r_cnt}) : pos_ext;
        in_rng  = !adj[11] && (adj[10:0] < r_cnt);
        full    = (r_cnt == CNT_W'(DEPTH));
        empty   = (r_cnt == '0);
        cnt_m1  = r_cnt - 1'b1;
        ld_idx  = adj[IDX_W-1:0];
        ld_ptr  = '0;
        ld_left = '0;
        ld_down = 1'b0;
        ld_st   = ST_OK;
        unique case (t_func'(i_func))
            F_READ: begin
                ld_ptr  = ld_idx;
                ld_st   = in_rng ? ST_OK : ST_RANGE;
                ld_left = in_rng ? CNT_W'(1) : '0;
            end
            F_APPEND: ld_st = full ? ST_FULL : ST_OK;
            F_POP: begin
                ld_ptr  = cnt_m1[IDX_W-1:0];
                ld_st   = empty ? ST_EMPTY : ST_OK;
                ld_left = empty ? '0 : CNT_W'(1);
            end
            F_INSERT: begin
                ld_ptr  = cnt_m1[IDX_W-1:0];
                ld_down = 1'b1;
                ld_st   = !in_rng ? ST_RANGE : (full ? ST_FULL : ST_OK);
                ld_left = (in_rng && !full) ? r_cnt - {1'b0, ld_idx} : '0;
            end
            F_PREPEND: begin
                ld_idx  = '0;
                ld_ptr  = cnt_m1[IDX_W-1:0];
                ld_down = 1'b1;
                ld_st   = full ? ST_FULL : ST_OK;
                ld_left = full ? '0 : r_cnt;
            end
            F_DELETE: begin
                ld_ptr  = ld_idx;
                ld_st   = in_rng ? ST_OK : ST_RANGE;
                ld_left = in_rng ? r_cnt - {1'b0, ld_idx} : '0;
            end
            F_REMOVE: ld_left = r_cnt;
            F_FIND: begin
                ld_left = r_cnt;
                ld_st   = ST_NOTFOUND;
            end
            default: ld_st = ST_OK;
        endcase
    end

    assign rd_en           = i_cmd.walk && (r_left != '0);
    assign o_sts.walk_done = (r_left == '0) && !r_pend;

    // write port: shift/compaction traffic during the walk, new word at finish
    always_comb begin
        we = 1'b0;
        wa = r_idx;
        wd = r_val;
        if (r_pend) begin
            case (r_func) inside
                F_INSERT, F_PREPEND: begin
                    we = 1'b1;
                    wa = r_paddr + 1'b1;
                    wd = mem_q;
                end
                F_DELETE: begin
                    we = (r_paddr != r_idx);
                    wa = r_paddr - 1'b1;
                    wd = mem_q;
                end
                F_REMOVE: begin
                    we = (mem_q != r_val);
                    wa = r_k[IDX_W-1:0];
                    wd = mem_q;
                end
                default: we = 1'b0;
            endcase
        end else if (i_cmd.finish && (r_st == ST_OK)) begin
            case (r_func) inside
                F_APPEND: begin
                    we = 1'b1;
                    wa = r_cnt[IDX_W-1:0];
                end
                F_INSERT, F_PREPEND: we = 1'b1;
                default: we = 1'b0;
            endcase
        end
    end

    // result fields, latched at finish
    always_comb begin
        n_res_data    = '0;
        n_res_found   = '0;
        n_res_removed = '0;
        if (r_st == ST_OK) begin
            case (r_func) inside
                F_READ, F_POP, F_DELETE:       n_res_data    = r_cap;
                F_APPEND, F_INSERT, F_PREPEND: n_res_data    = r_val;
                F_REMOVE:                      n_res_removed = r_cnt - r_k;
                F_FIND:                        n_res_found   = r_found;
                default:                       n_res_data    = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            mem_q <= mem[r_ptr];
        end
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_left <= '0;
        end else begin
            r_pend <= rd_en;
            if (i_cmd.load) begin
                r_left <= ld_left;
            end else if (rd_en) begin
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.finish && (r_st == ST_OK)) begin
                case (r_func) inside
                    F_APPEND, F_INSERT, F_PREPEND: r_cnt <= r_cnt + 1'b1;
                    F_POP, F_DELETE:               r_cnt <= r_cnt - 1'b1;
                    F_REMOVE:                      r_cnt <= r_k;
                    default:                       r_cnt <= r_cnt;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_val   <= i_item_value;
            r_idx   <= ld_idx;
            r_ptr   <= ld_ptr;
            r_down  <= ld_down;
            r_st    <= ld_st;
            r_k     <= '0;
            r_found <= '0;
            r_cap   <= '0;
        end else begin
            if (rd_en) begin
                r_paddr <= r_ptr;
                r_ptr   <= r_down ? r_ptr - 1'b1 : r_ptr + 1'b1;
            end
            if (r_pend) begin
                case (r_func) inside
                    F_READ, F_POP: r_cap <= mem_q;
                    F_DELETE: if (r_paddr == r_idx) r_cap <= mem_q;
                    F_REMOVE: if (mem_q != r_val) r_k <= r_k + 1'b1;
                    F_FIND: begin
                        if ((mem_q == r_val) && (r_st == ST_NOTFOUND)) begin
                            r_found <= r_paddr;
                            r_st    <= ST_OK;
                        end
                    end
                    default: r_cap <= r_cap;
                endcase
            end
        end
        if (i_cmd.finish) begin
            r_res_st      <= r_st;
            r_res_data    <= n_res_data;
            r_res_found   <= n_res_found;
            r_res_removed <= n_res_removed;
        end
    end

    assign o_data    = r_res_data;
    assign o_found   = r_res_found;
    assign o_removed = r_res_removed;
    assign o_length  = r_cnt;
    assign o_status  = r_res_st;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cmd.walk))
        else $error("memory read outside walk");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (r_left == '0) && !r_pend)
        else $error("finish while walk still busy");

endmodule
